@@ sv/ipfc_pkg.sv @@
package ipfc_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;
    localparam int BUCKET_W    = 16;

    localparam logic [15:0] TYPE_VLAN = 16'h8100;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;

    localparam logic [1:0] ST_NOT_IP = 2'd0;
    localparam logic [1:0] ST_NEW    = 2'd1;
    localparam logic [1:0] ST_HIT    = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic                is_ip;
        logic [31:0]         lo;
        logic [31:0]         hi;
        logic [15:0]         len;
        logic [BUCKET_W-1:0] bucket;
    } item_t;

endpackage

@@ sv/ipfc_if.sv @@
interface ipfc_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] eth_type;
    logic [15:0] inner_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] frame_len;

    modport source (output valid, eth_type, inner_type, src_addr, dst_addr, frame_len,
                    input ready);
    modport sink   (input valid, eth_type, inner_type, src_addr, dst_addr, frame_len,
                    output ready);
endinterface

interface ipfc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic [31:0] packet_count;
    logic [31:0] byte_count;

    modport source (output valid, status, addr_low, addr_high, packet_count, byte_count,
                    input ready);
    modport sink   (input valid, status, addr_low, addr_high, packet_count, byte_count,
                    output ready);
endinterface

@@ sv/ipfc_front.sv @@
module ipfc_front #(
    parameter int BUCKETS = ipfc_pkg::BUCKETS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ipfc_hdr_if.sink             hdr,
    output logic                 push_valid,
    input  logic                 push_ready,
    output ipfc_pkg::item_t      push_item
);

    localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [31:0] MASK  = 32'(BUCKETS - 1);
    localparam logic [31:0] DIVR  = 32'(BUCKETS);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

    typedef enum logic [2:0] {IDLE, MUL, RED, FIX, PUSH} state_t;

    state_t          state_reg;
    ipfc_pkg::item_t item_reg;
    logic [31:0]     xor_reg;
    logic [31:0]     quo_reg;
    logic [31:0]     rem_reg;

    logic            is_ip;
    logic [31:0]     xv;
    logic [63:0]     prod;

    always_comb
    begin
        if (hdr.eth_type == ipfc_pkg::TYPE_VLAN)
            is_ip = (hdr.inner_type == ipfc_pkg::TYPE_IPV4);
        else
            is_ip = (hdr.eth_type == ipfc_pkg::TYPE_IPV4);
        xv   = hdr.src_addr ^ hdr.dst_addr;
        prod = {32'd0, xor_reg} * {32'd0, RECIP};
    end

    assign hdr.ready  = (state_reg == IDLE);
    assign push_valid = (state_reg == PUSH);
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (hdr.valid)
                    begin
                        item_reg.is_ip <= is_ip;
                        item_reg.len   <= hdr.frame_len;
                        if (hdr.src_addr <= hdr.dst_addr)
                        begin
                            item_reg.lo <= hdr.src_addr;
                            item_reg.hi <= hdr.dst_addr;
                        end
                        else
                        begin
                            item_reg.lo <= hdr.dst_addr;
                            item_reg.hi <= hdr.src_addr;
                        end
                        item_reg.bucket <= ipfc_pkg::BUCKET_W'(xv & MASK);
                        xor_reg   <= xv;
                        state_reg <= (POW2 || !is_ip) ? PUSH : MUL;
                    end
                end
                MUL:
                begin
                    // reciprocal estimate of the quotient, at most one low
                    quo_reg   <= prod[63:32];
                    state_reg <= RED;
                end
                RED:
                begin
                    rem_reg   <= xor_reg - quo_reg * DIVR;
                    state_reg <= FIX;
                end
                FIX:
                begin
                    if (rem_reg >= DIVR)
                        item_reg.bucket <= ipfc_pkg::BUCKET_W'(rem_reg - DIVR);
                    else
                        item_reg.bucket <= ipfc_pkg::BUCKET_W'(rem_reg);
                    state_reg <= PUSH;
                end
                PUSH:
                begin
                    if (push_ready)
                        state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/ipfc_fifo.sv @@
module ipfc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ipfc_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ipfc_pkg::item_t pop_item
);

    ipfc_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

@@ sv/ipfc_back.sv @@
module ipfc_back #(
    parameter int BUCKETS = ipfc_pkg::BUCKETS_DEF,
    parameter int WAYS    = ipfc_pkg::WAYS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  ipfc_pkg::item_t pop_item,
    ipfc_res_if.source      res
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    typedef enum logic [1:0] {CLEAR, IDLE, LOOK} state_t;

    state_t                     state_reg;
    logic [BW-1:0]              clr_reg;
    ipfc_pkg::item_t            cur_reg;

    logic [WAYS-1:0]            mem_v  [BUCKETS];
    logic [WAYS-1:0][31:0]      mem_lo [BUCKETS];
    logic [WAYS-1:0][31:0]      mem_hi [BUCKETS];
    logic [WAYS-1:0][31:0]      mem_pk [BUCKETS];
    logic [WAYS-1:0][31:0]      mem_by [BUCKETS];

    logic [WAYS-1:0]            rd_v_reg;
    logic [WAYS-1:0][31:0]      rd_lo_reg;
    logic [WAYS-1:0][31:0]      rd_hi_reg;
    logic [WAYS-1:0][31:0]      rd_pk_reg;
    logic [WAYS-1:0][31:0]      rd_by_reg;

    logic                       out_valid_reg;
    logic [1:0]                 out_status_reg;
    logic [31:0]                out_lo_reg;
    logic [31:0]                out_hi_reg;
    logic [31:0]                out_pk_reg;
    logic [31:0]                out_by_reg;

    logic                       out_free;
    logic                       out_set;
    logic                       rd_en;
    logic [BW-1:0]              rd_addr;
    logic [BW-1:0]              cur_addr;
    logic [WAYS-1:0]            hit;
    logic                       any_hit;
    logic                       any_free;
    logic [WAYS-1:0]            hit_sel;
    logic [WAYS-1:0]            free_sel;
    logic [31:0]                sel_pk;
    logic [31:0]                sel_by;
    logic [31:0]                new_pk;
    logic [31:0]                new_by;
    logic                       wr_en;
    logic [BW-1:0]              wr_addr;
    logic [WAYS-1:0]            wr_v;
    logic [WAYS-1:0][31:0]      wr_lo;
    logic [WAYS-1:0][31:0]      wr_hi;
    logic [WAYS-1:0][31:0]      wr_pk;
    logic [WAYS-1:0][31:0]      wr_by;

    assign out_free  = !out_valid_reg || res.ready;
    assign pop_ready = (state_reg == IDLE) && out_free;
    assign rd_en     = pop_valid && pop_ready && pop_item.is_ip;
    assign rd_addr   = BW'(pop_item.bucket);
    assign cur_addr  = BW'(cur_reg.bucket);
    assign out_set   = (state_reg == LOOK)
                       || (pop_valid && pop_ready && !pop_item.is_ip);

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.addr_low     = out_lo_reg;
    assign res.addr_high    = out_hi_reg;
    assign res.packet_count = out_pk_reg;
    assign res.byte_count   = out_by_reg;

    always_comb
    begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_sel  = '0;
        free_sel = '0;
        sel_pk   = '0;
        sel_by   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w] = rd_v_reg[w] && (rd_lo_reg[w] == cur_reg.lo)
                     && (rd_hi_reg[w] == cur_reg.hi);
        end
        // lowest matching way, else lowest free way
        for (int w = 0; w < WAYS; w++)
        begin
            if (hit[w] && !any_hit)
            begin
                any_hit    = 1'b1;
                hit_sel[w] = 1'b1;
                sel_pk     = rd_pk_reg[w];
                sel_by     = rd_by_reg[w];
            end
            if (!rd_v_reg[w] && !any_free)
            begin
                any_free    = 1'b1;
                free_sel[w] = 1'b1;
            end
        end
        new_pk = sel_pk + 32'd1;
        new_by = sel_by + 32'(cur_reg.len);

        wr_v  = rd_v_reg;
        wr_lo = rd_lo_reg;
        wr_hi = rd_hi_reg;
        wr_pk = rd_pk_reg;
        wr_by = rd_by_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (any_hit && hit_sel[w])
            begin
                wr_pk[w] = new_pk;
                wr_by[w] = new_by;
            end
            else if (!any_hit && free_sel[w])
            begin
                wr_v[w]  = 1'b1;
                wr_lo[w] = cur_reg.lo;
                wr_hi[w] = cur_reg.hi;
                wr_pk[w] = 32'd1;
                wr_by[w] = 32'(cur_reg.len);
            end
        end

        wr_en   = 1'b0;
        wr_addr = cur_addr;
        if (state_reg == CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_v    = '0;
        end
        else if (state_reg == LOOK)
        begin
            wr_en = any_hit || any_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_v[wr_addr]  <= wr_v;
            mem_lo[wr_addr] <= wr_lo;
            mem_hi[wr_addr] <= wr_hi;
            mem_pk[wr_addr] <= wr_pk;
            mem_by[wr_addr] <= wr_by;
        end
        if (rd_en)
        begin
            rd_v_reg  <= mem_v[rd_addr];
            rd_lo_reg <= mem_lo[rd_addr];
            rd_hi_reg <= mem_hi[rd_addr];
            rd_pk_reg <= mem_pk[rd_addr];
            rd_by_reg <= mem_by[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_set)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == BW'(BUCKETS - 1))
                        state_reg <= IDLE;
                end
                IDLE:
                begin
                    if (pop_valid && out_free)
                    begin
                        cur_reg <= pop_item;
                        if (pop_item.is_ip)
                        begin
                            state_reg <= LOOK;
                        end
                        else
                        begin
                            out_status_reg <= ipfc_pkg::ST_NOT_IP;
                            out_lo_reg     <= '0;
                            out_hi_reg     <= '0;
                            out_pk_reg     <= '0;
                            out_by_reg     <= '0;
                        end
                    end
                end
                LOOK:
                begin
                    out_lo_reg    <= cur_reg.lo;
                    out_hi_reg    <= cur_reg.hi;
                    if (any_hit)
                    begin
                        out_status_reg <= ipfc_pkg::ST_HIT;
                        out_pk_reg     <= new_pk;
                        out_by_reg     <= new_by;
                    end
                    else if (any_free)
                    begin
                        out_status_reg <= ipfc_pkg::ST_NEW;
                        out_pk_reg     <= 32'd1;
                        out_by_reg     <= 32'(cur_reg.len);
                    end
                    else
                    begin
                        out_status_reg <= ipfc_pkg::ST_FULL;
                        out_pk_reg     <= '0;
                        out_by_reg     <= '0;
                    end
                    state_reg <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/ip_flow_counter_table.sv @@
// Bidirectional IPv4 flow counter. One result per header transfer. The front
// takes a header through IDLE and PUSH when BUCKETS is a power of two or the
// header is not IPv4, and through IDLE, MUL, RED, FIX and PUSH otherwise (the
// bucket remainder takes a reciprocal multiply, a multiply-subtract and one
// correcting subtract); the back does a read-modify-write of one bucket row in
// IDLE and LOOK. The front takes no new header until the last one is pushed. A
// 2-entry queue sits between them. After reset the table runs a clearing pass
// over all BUCKETS rows before the first header reaches the table.
module ip_flow_counter_table #(
    parameter int BUCKETS = ipfc_pkg::BUCKETS_DEF,
    parameter int WAYS    = ipfc_pkg::WAYS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ipfc_hdr_if.sink   hdr,
    ipfc_res_if.source res
);

    logic            push_valid;
    logic            push_ready;
    ipfc_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    ipfc_pkg::item_t pop_item;

    ipfc_front #(.BUCKETS(BUCKETS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdr        (hdr),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ipfc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ipfc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res       (res)
    );

endmodule

@@ sv/ipfc_checker.sv @@
module ipfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  status,
    input logic [31:0] addr_low,
    input logic [31:0] addr_high,
    input logic [31:0] packet_count,
    input logic [31:0] byte_count
);

    a_not_ip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ipfc_pkg::ST_NOT_IP |->
            addr_low == 32'd0 && addr_high == 32'd0 && packet_count == 32'd0
            && byte_count == 32'd0)
        else $error("not_ip result carries data");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ipfc_pkg::ST_FULL |->
            packet_count == 32'd0 && byte_count == 32'd0)
        else $error("dropped result carries counts");

    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ipfc_pkg::ST_NEW |-> packet_count == 32'd1)
        else $error("new flow packet count not one");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ipfc_pkg::ST_NOT_IP |-> addr_low <= addr_high)
        else $error("address pair out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(packet_count))
        else $error("stalled result changed");

endmodule

bind ip_flow_counter_table ipfc_checker u_ipfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .status       (res.status),
    .addr_low     (res.addr_low),
    .addr_high    (res.addr_high),
    .packet_count (res.packet_count),
    .byte_count   (res.byte_count)
);

@@ tb/ip_flow_counter_table_test.sv @@
module ip_flow_counter_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKETS = ipfc_pkg::BUCKETS_DEF;
    localparam int WAYS    = ipfc_pkg::WAYS_DEF;
    localparam int SLOTS   = BUCKETS * WAYS;

    typedef struct packed {
        logic [15:0] eth_type;
        logic [15:0] inner_type;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] frame_len;
    } header_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr_low;
        logic [31:0] addr_high;
        logic [31:0] packet_count;
        logic [31:0] byte_count;
    } flow_result_t;

    logic clk;
    logic rst_n;

    ipfc_hdr_if hdr ();
    ipfc_res_if res ();

    ip_flow_counter_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr.sink),
        .res   (res.source)
    );

    // table copy
    logic        slot_used [SLOTS];
    logic [63:0] slot_pair [SLOTS];
    logic [31:0] slot_pkts [SLOTS];
    logic [31:0] slot_bytes[SLOTS];

    flow_result_t expected_flows[$];
    int           error_count = 0;
    int           burst_left;
    int           stall_mode = 0;

    // flows reused by the random part
    logic [31:0] pool_a[$];
    logic [31:0] pool_b[$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic flow_result_t count_flow(input header_t h);
        flow_result_t r;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [63:0]  key;
        int           base;
        int           free_slot;
        r = '0;
        if (h.eth_type == ipfc_pkg::TYPE_VLAN ? h.inner_type != ipfc_pkg::TYPE_IPV4
                                              : h.eth_type != ipfc_pkg::TYPE_IPV4)
        begin
            r.status = ipfc_pkg::ST_NOT_IP;
            return r;
        end
        lo = (h.src_addr <= h.dst_addr) ? h.src_addr : h.dst_addr;
        hi = (h.src_addr <= h.dst_addr) ? h.dst_addr : h.src_addr;
        key = {lo, hi};
        base = ((h.src_addr ^ h.dst_addr) % BUCKETS) * WAYS;
        r.addr_low  = lo;
        r.addr_high = hi;
        free_slot = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (slot_used[base + w])
            begin
                if (slot_pair[base + w] == key)
                begin
                    slot_pkts[base + w]  = slot_pkts[base + w] + 32'd1;
                    slot_bytes[base + w] = slot_bytes[base + w] + {16'd0, h.frame_len};
                    r.status       = ipfc_pkg::ST_HIT;
                    r.packet_count = slot_pkts[base + w];
                    r.byte_count   = slot_bytes[base + w];
                    return r;
                end
            end
            else if (free_slot < 0)
                free_slot = base + w;
        end
        if (free_slot < 0)
        begin
            r.status = ipfc_pkg::ST_FULL;
            return r;
        end
        slot_used[free_slot]  = 1'b1;
        slot_pair[free_slot]  = key;
        slot_pkts[free_slot]  = 32'd1;
        slot_bytes[free_slot] = {16'd0, h.frame_len};
        r.status       = ipfc_pkg::ST_NEW;
        r.packet_count = 32'd1;
        r.byte_count   = {16'd0, h.frame_len};
        return r;
    endfunction

    task automatic send_header(input header_t h);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                hdr.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        hdr.valid      <= 1'b1;
        hdr.eth_type   <= h.eth_type;
        hdr.inner_type <= h.inner_type;
        hdr.src_addr   <= h.src_addr;
        hdr.dst_addr   <= h.dst_addr;
        hdr.frame_len  <= h.frame_len;
        @(posedge clk);
        while (!hdr.ready)
            @(posedge clk);
        expected_flows.insert(expected_flows.size(), count_flow(h));
    endtask

    function automatic header_t ipv4(input logic [31:0] s, input logic [31:0] d,
                                     input logic [15:0] len);
        header_t h;
        h.eth_type   = $urandom_range(0, 1) ? ipfc_pkg::TYPE_IPV4 : ipfc_pkg::TYPE_VLAN;
        h.inner_type = (h.eth_type == ipfc_pkg::TYPE_VLAN) ? ipfc_pkg::TYPE_IPV4
                                                           : 16'($urandom);
        h.src_addr   = s;
        h.dst_addr   = d;
        h.frame_len  = len;
        return h;
    endfunction

    // receiver stall pattern
    always @(posedge clk)
    begin
        int cyc;
        cyc = $urandom_range(0, 99);
        if (cyc < 2)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= cyc[0];
            2: res.ready <= (cyc < 20);
            default: res.ready <= (cyc >= 10);
        endcase
    end

    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_flows.size() == 0)
            begin
                report_mismatch("unexpected transfer", 32'(res.status), 32'd0);
            end
            else
            begin
                want = expected_flows.pop_front();
                if (res.status !== want.status)
                    report_mismatch("status", 32'(res.status), 32'(want.status));
                if (res.addr_low !== want.addr_low)
                    report_mismatch("addr_low", res.addr_low, want.addr_low);
                if (res.addr_high !== want.addr_high)
                    report_mismatch("addr_high", res.addr_high, want.addr_high);
                if (res.packet_count !== want.packet_count)
                    report_mismatch("packet_count", res.packet_count, want.packet_count);
                if (res.byte_count !== want.byte_count)
                    report_mismatch("byte_count", res.byte_count, want.byte_count);
            end
        end
    end

    task automatic test_ethertypes();
        header_t h;
        h = '{16'h0800, 16'h0000, 32'h0A000001, 32'h0A000002, 16'd64};
        send_header(h);
        h = '{16'h8100, 16'h0800, 32'h0A000002, 32'h0A000001, 16'd100};
        send_header(h);
        h = '{16'h8100, 16'h8100, 32'h0A000001, 32'h0A000002, 16'd9};
        send_header(h);
        h = '{16'h86DD, 16'h0800, 32'h01020304, 32'h05060708, 16'hFFFF};
        send_header(h);
        h = '{16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF};
        send_header(h);
        h = '{16'h0000, 16'h0000, 32'h0, 32'h0, 16'h0};
        send_header(h);
        h = '{16'h8100, 16'hFFFF, 32'h1, 32'h2, 16'h1};
        send_header(h);
    endtask

    task automatic test_extremes();
        send_header(ipv4(32'h0, 32'h0, 16'd0));
        send_header(ipv4(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
        send_header(ipv4(32'hFFFFFFFF, 32'h0, 16'hFFFF));
        send_header(ipv4(32'h0, 32'hFFFFFFFF, 16'hFFFF));
        send_header(ipv4(32'h0, 32'h0, 16'hFFFF));
    endtask

    // six pairs sharing bucket 0x11: four fill it, the rest drop; a reversed pair hits
    task automatic test_bucket_full();
        for (int k = 0; k < WAYS + 2; k++)
            send_header(ipv4(32'h100 * (k + 1), 32'h100 * (k + 1) ^ 32'h11, 16'd40));
        send_header(ipv4(32'h200 ^ 32'h11, 32'h200, 16'd40));
    endtask

    // one flow with maximum lengths
    task automatic test_wrap();
        for (int k = 0; k < 6; k++)
            send_header(ipv4(32'hC0A80001, 32'hC0A80002, 16'hFFFF));
    endtask

    task automatic test_random_traffic(input int count);
        header_t     h;
        logic [31:0] s;
        logic [31:0] d;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                h = header_t'(112'({$urandom, $urandom, $urandom, $urandom}));
                if (pick < 3)
                    h.eth_type = ipfc_pkg::TYPE_VLAN;
                send_header(h);
            end
            else
            begin
                if (pick < 45 || pool_a.size() == 0)
                begin
                    s = $urandom;
                    // crowd a few buckets so some fill up
                    d = (pick < 25) ? (s ^ 32'($urandom_range(0, 7))
                                      ^ (32'($urandom_range(0, 255)) << 16))
                                    : $urandom;
                    if (pool_a.size() < 64)
                    begin
                        pool_a.insert(pool_a.size(), s);
                        pool_b.insert(pool_b.size(), d);
                    end
                end
                else
                begin
                    pick = $urandom_range(0, pool_a.size() - 1);
                    s = pool_a[pick];
                    d = pool_b[pick];
                    if ($urandom_range(0, 1))
                    begin
                        s = pool_b[pick];
                        d = pool_a[pick];
                    end
                end
                send_header(ipv4(s, d, 16'($urandom)));
            end
        end
    endtask

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        hdr.valid      = 1'b0;
        hdr.eth_type   = '0;
        hdr.inner_type = '0;
        hdr.src_addr   = '0;
        hdr.dst_addr   = '0;
        hdr.frame_len  = '0;
        burst_left     = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_pair[i]  = '0;
            slot_pkts[i]  = '0;
            slot_bytes[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ethertypes();
        test_extremes();
        test_bucket_full();
        test_wrap();
        test_random_traffic(1425);
        hdr.valid <= 1'b0;

        waited = 0;
        while (expected_flows.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_flows.size() == 0)
            $display("ip_flow_counter_table test passed");
        else
            $display("ip_flow_counter_table test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("ip_flow_counter_table test failed");
        $finish;
    end

endmodule
